>>> design/oscl_pkg.sv
// Shared types and constants for the occlusion span clip list.
// Used by the controller, the datapath, the top level and the checker.
package oscl_pkg;

  localparam int MAX_RANGES = 32;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int FRAG_W     = 11;
  localparam int VW_W       = 12;
  localparam int COL_W      = 14;

  typedef logic signed [COL_W-1:0] col_t;

  localparam col_t LOW_MARK  = col_t'(-4096);
  localparam col_t HIGH_MARK = col_t'(4095);

  localparam logic [1:0] REQ_SOLID = 2'd0;
  localparam logic [1:0] REQ_PASS  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FRAG_W-1:0] span_first;
    logic [FRAG_W-1:0] span_last;
  } req_t;

  typedef struct packed {
    logic              frag_valid;
    logic [FRAG_W-1:0] frag_first;
    logic [FRAG_W-1:0] frag_last;
    logic              last_of_run;
    logic              overflow;
  } res_t;

  typedef struct packed {
    col_t start_col;
    col_t end_col;
  } entry_t;

  typedef enum logic [1:0] {RD_ZERO, RD_NEXT, RD_PTR} rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_NEW, WR_HELD, WR_SEG, WR_MOVE, WR_SENT_LO, WR_SENT_HI
  } wr_sel_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_EMPTY, EM_SPAN, EM_LEFT, EM_GAP, EM_TAIL
  } em_sel_t;

  typedef enum logic [1:0] {SEG_HOLD, SEG_OPEN, SEG_END_E, SEG_END_L} seg_op_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INIT, CNT_INC, CNT_SUB} cnt_op_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    em_sel_t em_sel;
    logic    em_last;
    logic    em_ovf;
    logic    ptr_inc;
    logic    base_set;
    logic    held_load;
    seg_op_t seg_op;
    logic    gap_inc;
    cnt_op_t cnt_op;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_clip;
    logic solid;
    logic touch;
    logic left;
    logic ahead;
    logic covered;
    logic full;
    logic ptr_at_cnt;
    logic ptr_at_top;
    logic gap_zero;
  } stat_t;

endpackage

>>> design/occlusion_span_clip_list.sv
// Top level of the occlusion span clip list with its configuration register.
// Depends on oscl_pkg, oscl_ctrl and oscl_dp.
//
// A request item is taken at a clock edge where start is high and busy is
// low. It clips [span_first, span_last] against the stored list of covered
// column ranges. Every visible fragment comes out as one result item on res,
// marked by res_strobe for a single cycle; the final item of a request has
// last_of_run set, and a request with no visible fragment gives one empty
// item. The receiver cannot stall, so results are never held back.
// The first result follows the scan that finds the first touching range. The
// range memory, with one read and one write port, is walked one entry per
// cycle for the scan, the insert shift or the removal of swallowed ranges.
// After reset the two sentinel entries are written with busy high and
// view_width returns to 320. view_width sits at byte address 0 of the APB
// port and is used at the next clear or reset.
module occlusion_span_clip_list (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  oscl_pkg::req_t req,
  output logic           res_strobe,
  output oscl_pkg::res_t res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam logic [1:0] REG_VIEW_WIDTH = 2'd0;
  localparam logic [oscl_pkg::VW_W-1:0] VIEW_WIDTH_RST = 12'd320;

  logic [oscl_pkg::VW_W-1:0] view_width;
  oscl_pkg::cmd_t            cmd;
  oscl_pkg::stat_t           stat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VIEW_WIDTH) ?
                  {{(32-oscl_pkg::VW_W){1'b0}}, view_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width <= VIEW_WIDTH_RST;
    end else if (psel && penable && pwrite && (paddr == REG_VIEW_WIDTH)) begin
      view_width <= pwdata[oscl_pkg::VW_W-1:0];
    end
  end

  oscl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  oscl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .view_width (view_width),
    .cmd        (cmd),
    .stat       (stat),
    .res_strobe (res_strobe),
    .res        (res)
  );

endmodule

>>> design/oscl_ctrl.sv
// Controller state machine of the occlusion span clip list.
// Depends on oscl_pkg for the command and status types.
module oscl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  oscl_pkg::stat_t stat,
  output logic           busy,
  output oscl_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLR_LO, S_CLR_HI, S_SCAN, S_SHIFT, S_MERGE, S_WRITE, S_COMPACT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_LO;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.rd_sel    = oscl_pkg::RD_NEXT;
    cmd.wr_sel    = oscl_pkg::WR_NONE;
    cmd.em_sel    = oscl_pkg::EM_NONE;
    cmd.em_last   = 1'b0;
    cmd.em_ovf    = 1'b0;
    cmd.ptr_inc   = 1'b0;
    cmd.base_set  = 1'b0;
    cmd.held_load = 1'b0;
    cmd.seg_op    = oscl_pkg::SEG_HOLD;
    cmd.gap_inc   = 1'b0;
    cmd.cnt_op    = oscl_pkg::CNT_HOLD;
    unique case (state)
      S_IDLE: begin
        cmd.rd_sel = oscl_pkg::RD_ZERO;
        if (start) begin
          cmd.load = 1'b1;
          if (stat.in_clear) begin
            cmd.em_sel  = oscl_pkg::EM_EMPTY;
            cmd.em_last = 1'b1;
            state_next  = S_CLR_LO;
          end else if (stat.in_clip) begin
            state_next = S_SCAN;
          end else begin
            cmd.em_sel  = oscl_pkg::EM_EMPTY;
            cmd.em_last = 1'b1;
          end
        end
      end
      S_CLR_LO: begin
        cmd.wr_sel = oscl_pkg::WR_SENT_LO;
        state_next = S_CLR_HI;
      end
      S_CLR_HI: begin
        cmd.wr_sel = oscl_pkg::WR_SENT_HI;
        cmd.cnt_op = oscl_pkg::CNT_INIT;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (!stat.touch) begin
          cmd.ptr_inc = 1'b1;
        end else begin
          cmd.base_set = 1'b1;
          if (stat.left && stat.ahead) begin
            cmd.em_sel  = oscl_pkg::EM_SPAN;
            cmd.em_last = 1'b1;
            cmd.em_ovf  = stat.solid && stat.full;
            if (stat.solid && !stat.full) begin
              cmd.wr_sel    = oscl_pkg::WR_NEW;
              cmd.held_load = 1'b1;
              cmd.ptr_inc   = 1'b1;
              state_next    = S_SHIFT;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.seg_op = oscl_pkg::SEG_OPEN;
            if (stat.covered) begin
              cmd.em_sel  = stat.left ? oscl_pkg::EM_LEFT : oscl_pkg::EM_EMPTY;
              cmd.em_last = 1'b1;
              state_next  = stat.solid ? S_WRITE : S_IDLE;
            end else begin
              if (stat.left) begin
                cmd.em_sel = oscl_pkg::EM_LEFT;
              end
              cmd.ptr_inc = 1'b1;
              state_next  = S_MERGE;
            end
          end
        end
      end
      S_SHIFT: begin
        cmd.wr_sel    = oscl_pkg::WR_HELD;
        cmd.held_load = 1'b1;
        if (stat.ptr_at_cnt) begin
          cmd.cnt_op = oscl_pkg::CNT_INC;
          state_next = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_MERGE: begin
        if (!stat.ahead) begin
          cmd.em_sel  = oscl_pkg::EM_GAP;
          cmd.em_last = stat.covered;
          cmd.seg_op  = oscl_pkg::SEG_END_E;
          cmd.gap_inc = 1'b1;
          cmd.ptr_inc = 1'b1;
          if (stat.covered) begin
            state_next = stat.solid ? S_WRITE : S_IDLE;
          end
        end else begin
          cmd.em_sel  = oscl_pkg::EM_TAIL;
          cmd.em_last = 1'b1;
          cmd.seg_op  = oscl_pkg::SEG_END_L;
          state_next  = stat.solid ? S_WRITE : S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.rd_sel = oscl_pkg::RD_PTR;
        cmd.wr_sel = oscl_pkg::WR_SEG;
        if (stat.gap_zero) begin
          state_next = S_IDLE;
        end else if (stat.ptr_at_cnt) begin
          cmd.cnt_op = oscl_pkg::CNT_SUB;
          state_next = S_IDLE;
        end else begin
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        cmd.wr_sel = oscl_pkg::WR_MOVE;
        if (stat.ptr_at_top) begin
          cmd.cnt_op = oscl_pkg::CNT_SUB;
          state_next = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
    endcase
  end

endmodule

>>> design/oscl_dp.sv
// Datapath of the occlusion span clip list: range memory, pointers,
// comparators and the result register. Depends on oscl_pkg.
module oscl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  oscl_pkg::req_t                req,
  input  logic [oscl_pkg::VW_W-1:0]     view_width,
  input  oscl_pkg::cmd_t                cmd,
  output oscl_pkg::stat_t               stat,
  output logic                          res_strobe,
  output oscl_pkg::res_t                res
);

  localparam int IDX_W  = oscl_pkg::IDX_W;
  localparam int CNT_W  = oscl_pkg::CNT_W;
  localparam int COL_W  = oscl_pkg::COL_W;
  localparam int FRAG_W = oscl_pkg::FRAG_W;
  localparam int VW_W   = oscl_pkg::VW_W;

  oscl_pkg::entry_t mem [oscl_pkg::MAX_RANGES];
  oscl_pkg::entry_t rd_data;
  oscl_pkg::entry_t held;
  oscl_pkg::entry_t wdata;
  oscl_pkg::req_t   req_q;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] gap;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [CNT_W-1:0] move_addr;
  logic             we;

  oscl_pkg::col_t seg_start;
  oscl_pkg::col_t seg_end;
  oscl_pkg::col_t fc;
  oscl_pkg::col_t lc;
  oscl_pkg::col_t fm1;
  oscl_pkg::col_t sm1;
  oscl_pkg::col_t ep1;
  oscl_pkg::col_t vw_c;
  oscl_pkg::col_t em_first;
  oscl_pkg::col_t em_last_col;
  oscl_pkg::col_t s;
  oscl_pkg::col_t e;

  assign s    = rd_data.start_col;
  assign e    = rd_data.end_col;
  assign fc   = oscl_pkg::col_t'({{(COL_W-FRAG_W){1'b0}}, req_q.span_first});
  assign lc   = oscl_pkg::col_t'({{(COL_W-FRAG_W){1'b0}}, req_q.span_last});
  assign vw_c = oscl_pkg::col_t'({{(COL_W-VW_W){1'b0}}, view_width});
  assign fm1  = fc - oscl_pkg::col_t'(1);
  assign sm1  = s - oscl_pkg::col_t'(1);
  assign ep1  = seg_end + oscl_pkg::col_t'(1);
  assign move_addr = ptr - {1'b0, gap};

  assign stat.in_clear   = (req.req_type == oscl_pkg::REQ_CLEAR);
  assign stat.in_clip    = ((req.req_type == oscl_pkg::REQ_SOLID) ||
                            (req.req_type == oscl_pkg::REQ_PASS)) &&
                           (req.span_last >= req.span_first);
  assign stat.solid      = (req_q.req_type == oscl_pkg::REQ_SOLID);
  assign stat.touch      = (e >= fm1);
  assign stat.left       = (fc < s);
  assign stat.ahead      = (lc < sm1);
  assign stat.covered    = (lc <= e);
  assign stat.full       = (cnt >= CNT_W'(oscl_pkg::MAX_RANGES));
  assign stat.ptr_at_cnt = (ptr == cnt);
  assign stat.ptr_at_top = (ptr == cnt - CNT_W'(1));
  assign stat.gap_zero   = (gap == '0);

  always_comb begin
    unique case (cmd.rd_sel)
      oscl_pkg::RD_ZERO: raddr = '0;
      oscl_pkg::RD_PTR:  raddr = ptr[IDX_W-1:0];
      default:           raddr = IDX_W'(ptr + CNT_W'(1));
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = ptr[IDX_W-1:0];
    wdata = held;
    unique case (cmd.wr_sel)
      oscl_pkg::WR_NEW: begin
        wdata.start_col = fc;
        wdata.end_col   = lc;
      end
      oscl_pkg::WR_HELD: begin
        wdata = held;
      end
      oscl_pkg::WR_SEG: begin
        waddr           = base;
        wdata.start_col = seg_start;
        wdata.end_col   = seg_end;
      end
      oscl_pkg::WR_MOVE: begin
        waddr = move_addr[IDX_W-1:0];
        wdata = rd_data;
      end
      oscl_pkg::WR_SENT_LO: begin
        waddr           = IDX_W'(0);
        wdata.start_col = oscl_pkg::LOW_MARK;
        wdata.end_col   = oscl_pkg::col_t'(-1);
      end
      oscl_pkg::WR_SENT_HI: begin
        waddr           = IDX_W'(1);
        wdata.start_col = vw_c;
        wdata.end_col   = oscl_pkg::HIGH_MARK;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.load) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CNT_W'(1);
    end
    if (cmd.load) begin
      gap <= '0;
    end else if (cmd.gap_inc) begin
      gap <= gap + IDX_W'(1);
    end
    if (cmd.base_set) begin
      base <= ptr[IDX_W-1:0];
    end
    if (cmd.held_load) begin
      held <= rd_data;
    end
    unique case (cmd.seg_op)
      oscl_pkg::SEG_OPEN: begin
        seg_start <= stat.left ? fc : s;
        seg_end   <= e;
      end
      oscl_pkg::SEG_END_E: seg_end <= e;
      oscl_pkg::SEG_END_L: seg_end <= lc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_W'(2);
    end else begin
      unique case (cmd.cnt_op)
        oscl_pkg::CNT_INIT: cnt <= CNT_W'(2);
        oscl_pkg::CNT_INC:  cnt <= cnt + CNT_W'(1);
        oscl_pkg::CNT_SUB:  cnt <= cnt - {1'b0, gap};
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.em_sel)
      oscl_pkg::EM_SPAN: begin
        em_first    = fc;
        em_last_col = lc;
      end
      oscl_pkg::EM_LEFT: begin
        em_first    = fc;
        em_last_col = sm1;
      end
      oscl_pkg::EM_GAP: begin
        em_first    = ep1;
        em_last_col = sm1;
      end
      oscl_pkg::EM_TAIL: begin
        em_first    = ep1;
        em_last_col = lc;
      end
      default: begin
        em_first    = '0;
        em_last_col = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= (cmd.em_sel != oscl_pkg::EM_NONE);
    end
    if (cmd.em_sel != oscl_pkg::EM_NONE) begin
      res.frag_valid  <= (cmd.em_sel != oscl_pkg::EM_EMPTY);
      res.frag_first  <= em_first[FRAG_W-1:0];
      res.frag_last   <= em_last_col[FRAG_W-1:0];
      res.last_of_run <= cmd.em_last;
      res.overflow    <= cmd.em_ovf;
    end
  end

endmodule

>>> design/oscl_checker.sv
// Port-level checks for the occlusion span clip list, bound to the top level.
// Depends on oscl_pkg for the result type.
module oscl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           res_strobe,
  input oscl_pkg::res_t res
);

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    res_strobe && res.overflow |-> res.last_of_run && res.frag_valid)
    else $error("overflow on an item that is not a final fragment");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res.frag_valid |->
      res.last_of_run && (res.frag_first == '0) && (res.frag_last == '0))
    else $error("empty item is not a zeroed final item");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res.last_of_run |=> res_strobe)
    else $error("fragment run broken before its final item");

  a_accept_reacts: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (res_strobe && res.last_of_run))
    else $error("accepted item neither started work nor finished");

endmodule

bind occlusion_span_clip_list oscl_checker u_oscl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .res_strobe (res_strobe),
  .res        (res)
);
